// ===== sv/csvs_pkg.sv =====
// ---------------------------------------------------------------------------
// csvs_pkg
// Shared types, codes and constants for the csv line field splitter.
// ---------------------------------------------------------------------------
`default_nettype none

package csvs_pkg;

  localparam int BREAK_HOLD_DEPTH_DEF = 8;

  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CELLS = 1'b1;

  localparam logic [7:0]  SEPARATOR_RST = 8'd44;
  localparam logic [15:0] MAX_CELLS_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_CELL_END = 2'd1,
    KIND_LINE_END = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_MANY   = 2'd1,
    ST_OPEN_QUOTE = 2'd2,
    ST_BREAK_OVF  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_out;
    logic [15:0] cell_index;
    logic [15:0] cell_total;
    status_t     status;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic eval;
    logic drain;
    logic chr;
    logic report;
    logic flush;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_break;
    logic cnt_zero;
    logic drain_done;
    logic last;
    logic out_free;
    logic pend_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/csvs_in_if.sv =====
// ---------------------------------------------------------------------------
// csvs_in_if
// Input byte channel: valid/ready handshake with one line byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface csvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_last;

  modport source (output valid, output ch, output line_last, input ready);
  modport sink   (input valid, input ch, input line_last, output ready);
endinterface

`default_nettype wire

// ===== sv/csvs_out_if.sv =====
// ---------------------------------------------------------------------------
// csvs_out_if
// Result channel: valid/ready handshake with one result per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface csvs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_out;
  logic [15:0] cell_index;
  logic [15:0] cell_total;
  logic [1:0]  status;
  logic        run_last;

  modport source (output valid, output kind, output byte_out, output cell_index,
                  output cell_total, output status, output run_last, input ready);
  modport sink   (input valid, input kind, input byte_out, input cell_index,
                  input cell_total, input status, input run_last, output ready);
endinterface

`default_nettype wire

// ===== sv/csv_line_field_splitter.sv =====
// ---------------------------------------------------------------------------
// csv_line_field_splitter
// Splits the bytes of a text line into cells with quote and break handling.
// ---------------------------------------------------------------------------
// One byte is taken at a time, and no new byte is taken until the last one
// is through. A content byte steps through accept, evaluate, release of any
// held CR or LF bytes, handle and hand-off of the last result; a line's final
// content byte also passes through the line end report. A CR or LF byte is
// only stored after accept and evaluate, and goes on to report and hand-off
// when it is the line's final byte. The sequencer moves one result a cycle
// through a pending slot and the output register while the result channel
// does not stall.
`default_nettype none

module csv_line_field_splitter
  import csvs_pkg::*;
#(
  parameter int BREAK_HOLD_DEPTH = BREAK_HOLD_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  csvs_in_if.sink              in_chan,
  csvs_out_if.source           out_chan,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  res_t     out_res;
  logic     out_valid;
  logic     out_run_last;
  logic     in_ready;

  csvs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csvs_dp #(
    .BREAK_HOLD_DEPTH (BREAK_HOLD_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_chan.ch),
    .in_line_last (in_chan.line_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_chan.ready),
    .out_res      (out_res),
    .out_run_last (out_run_last)
  );

  assign in_chan.ready       = in_ready;
  assign out_chan.valid      = out_valid;
  assign out_chan.kind       = out_res.kind;
  assign out_chan.byte_out   = out_res.byte_out;
  assign out_chan.cell_index = out_res.cell_index;
  assign out_chan.cell_total = out_res.cell_total;
  assign out_chan.status     = out_res.status;
  assign out_chan.run_last   = out_run_last;

endmodule

`default_nettype wire

// ===== sv/csvs_ctrl.sv =====
// ---------------------------------------------------------------------------
// csvs_ctrl
// Sequencer: steps one input byte through evaluation, break release,
// byte handling, line report and final flush.
// ---------------------------------------------------------------------------
`default_nettype none

module csvs_ctrl
  import csvs_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DRAIN,
    S_CHAR,
    S_REPORT,
    S_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.is_break) begin
          state_nxt = stat.last ? S_REPORT : S_IDLE;
        end else begin
          state_nxt = stat.cnt_zero ? S_CHAR : S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.drain = 1'b1;
          if (stat.drain_done) state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        if (stat.out_free) begin
          cmd.chr   = 1'b1;
          state_nxt = stat.last ? S_REPORT : S_FLUSH;
        end
      end
      S_REPORT: begin
        if (stat.out_free) begin
          cmd.report = 1'b1;
          state_nxt  = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ===== sv/csvs_dp.sv =====
// ---------------------------------------------------------------------------
// csvs_dp
// Datapath: line state, held break store, config registers, one pending
// result and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module csvs_dp
  import csvs_pkg::*;
#(
  parameter int BREAK_HOLD_DEPTH = BREAK_HOLD_DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire [7:0]             in_ch,
  input  wire                   in_line_last,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  wire                   out_ready,
  output res_t                  out_res,
  output logic                  out_run_last
);

  localparam int CNT_W = $clog2(BREAK_HOLD_DEPTH + 1);
  localparam int IDX_W = (BREAK_HOLD_DEPTH > 1) ? $clog2(BREAK_HOLD_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BREAK_HOLD_DEPTH);

  logic [7:0]                  sep_r, sep_nxt;
  logic [15:0]                 max_r, max_nxt;
  logic [7:0]                  ch_r, ch_nxt;
  logic                        last_r, last_nxt;
  logic                        quoted_r, quoted_nxt;
  logic                        qtent_r, qtent_nxt;
  logic [15:0]                 cell_r, cell_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [BREAK_HOLD_DEPTH-1:0] brk_r, brk_nxt;
  logic [IDX_W-1:0]            didx_r, didx_nxt;
  logic                        seen_r, seen_nxt;
  status_t                     lstat_r, lstat_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  res_t                        pend_r, pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  res_t                        out_r, out_nxt;
  logic                        out_last_r, out_last_nxt;

  logic       ch_is_break;
  logic       out_free;
  logic       drain_done;
  logic [7:0] brk_byte;
  logic [7:0] pb_byte;
  logic       pb_sep;
  logic       pb_ovf;
  logic       res_vld;
  res_t       res;
  status_t    rep_st;

  assign ch_is_break = (ch_r == CR_BYTE) || (ch_r == LF_BYTE);
  assign out_free    = !out_valid_r || out_ready;
  assign drain_done  = (CNT_W'(didx_r) + CNT_W'(1)) == cnt_r;
  assign brk_byte    = brk_r[didx_r] ? LF_BYTE : CR_BYTE;
  assign pb_byte     = cmd.drain ? brk_byte : ch_r;
  assign pb_sep      = (pb_byte == sep_r) && !quoted_r;
  assign pb_ovf      = ({1'b0, cell_r} + 17'd1) >= {1'b0, max_r};

  assign stat.is_break   = ch_is_break;
  assign stat.cnt_zero   = (cnt_r == '0);
  assign stat.drain_done = drain_done;
  assign stat.last       = last_r;
  assign stat.out_free   = out_free;
  assign stat.pend_valid = pend_valid_r;

  assign out_valid    = out_valid_r;
  assign out_res      = out_r;
  assign out_run_last = out_last_r;

  always_comb begin
    sep_nxt        = sep_r;
    max_nxt        = max_r;
    ch_nxt         = ch_r;
    last_nxt       = last_r;
    quoted_nxt     = quoted_r;
    qtent_nxt      = qtent_r;
    cell_nxt       = cell_r;
    cnt_nxt        = cnt_r;
    brk_nxt        = brk_r;
    didx_nxt       = didx_r;
    seen_nxt       = seen_r;
    lstat_nxt      = lstat_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    res_vld        = 1'b0;
    res            = '{kind: KIND_BYTE, byte_out: 8'd0, cell_index: cell_r,
                       cell_total: 16'd0, status: ST_OK};
    rep_st         = lstat_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEPARATOR: sep_nxt = cfg_wdata[7:0];
        CFG_MAX_CELLS: max_nxt = cfg_wdata[15:0];
        default: ;
      endcase
    end

    if (cmd.latch) begin
      ch_nxt   = in_ch;
      last_nxt = in_line_last;
    end

    if (cmd.eval) begin
      didx_nxt = '0;
      if (ch_is_break) begin
        if (qtent_r) begin
          qtent_nxt  = 1'b0;
          quoted_nxt = 1'b0;
        end
        if (cnt_r < DEPTH_C) begin
          brk_nxt[cnt_r[IDX_W-1:0]] = (ch_r == LF_BYTE);
          cnt_nxt = cnt_r + CNT_W'(1);
        end else if (lstat_r == ST_OK) begin
          lstat_nxt = ST_BREAK_OVF;
        end
      end else begin
        seen_nxt = 1'b1;
        if (ch_r != QUOTE_BYTE && qtent_r) begin
          qtent_nxt  = 1'b0;
          quoted_nxt = 1'b0;
        end
      end
    end

    // ordinary byte: released break or a non-quote content byte
    if (cmd.drain || (cmd.chr && ch_r != QUOTE_BYTE)) begin
      if (pb_sep && pb_ovf) begin
        if (lstat_r == ST_OK) lstat_nxt = ST_TOO_MANY;
      end else if (pb_sep) begin
        res_vld  = 1'b1;
        res.kind = KIND_CELL_END;
        cell_nxt = cell_r + 16'd1;
      end else begin
        res_vld      = 1'b1;
        res.byte_out = pb_byte;
      end
    end

    if (cmd.drain) begin
      didx_nxt = didx_r + IDX_W'(1);
      if (drain_done) cnt_nxt = '0;
    end

    if (cmd.chr && ch_r == QUOTE_BYTE) begin
      if (qtent_r) begin
        qtent_nxt    = 1'b0;
        res_vld      = 1'b1;
        res.byte_out = QUOTE_BYTE;
      end else if (!quoted_r) begin
        quoted_nxt = 1'b1;
      end else begin
        qtent_nxt = 1'b1;
      end
    end

    if (cmd.report) begin
      res_vld        = 1'b1;
      res.kind       = KIND_LINE_END;
      res.cell_index = 16'd0;
      if (seen_r) begin
        if (rep_st == ST_OK && quoted_r && !qtent_r) rep_st = ST_OPEN_QUOTE;
        if (rep_st == ST_OK) res.cell_total = cell_r + 16'd1;
      end else begin
        rep_st = ST_OK;
      end
      // an all-break line still reports an overflow of the break store
      if (!seen_r) rep_st = lstat_r;
      res.status = rep_st;
      quoted_nxt = 1'b0;
      qtent_nxt  = 1'b0;
      cell_nxt   = 16'd0;
      cnt_nxt    = '0;
      seen_nxt   = 1'b0;
      lstat_nxt  = ST_OK;
    end

    // a result waits in the pending slot until the next one shows it is not last
    if (res_vld) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt = 1'b1;
      pend_nxt       = res;
    end

    if (cmd.flush && pend_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = pend_r;
      out_last_nxt   = 1'b1;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r        <= SEPARATOR_RST;
      max_r        <= MAX_CELLS_RST;
      quoted_r     <= 1'b0;
      qtent_r      <= 1'b0;
      cell_r       <= 16'd0;
      cnt_r        <= '0;
      seen_r       <= 1'b0;
      lstat_r      <= ST_OK;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      sep_r        <= sep_nxt;
      max_r        <= max_nxt;
      quoted_r     <= quoted_nxt;
      qtent_r      <= qtent_nxt;
      cell_r       <= cell_nxt;
      cnt_r        <= cnt_nxt;
      seen_r       <= seen_nxt;
      lstat_r      <= lstat_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    last_r     <= last_nxt;
    brk_r      <= brk_nxt;
    didx_r     <= didx_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/csvs_checker.sv =====
// ---------------------------------------------------------------------------
// csvs_checker
// Port-level checks on the result channel of the field splitter.
// ---------------------------------------------------------------------------
`default_nettype none

module csvs_checker
  import csvs_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  kind,
  input wire [7:0]  byte_out,
  input wire [15:0] cell_index,
  input wire [15:0] cell_total,
  input wire [1:0]  status,
  input wire        run_last
);

  // a stalled beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({kind, byte_out, cell_index,
                                                      cell_total, status, run_last}))
    else $error("result beat changed while stalled");

  // the line report closes every run of results
  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_LINE_END |-> run_last && cell_index == 16'd0)
    else $error("line end report not last or with a cell index");

  // only a line report carries a total or a status
  a_total_only_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_LINE_END |-> cell_total == 16'd0 && status == ST_OK)
    else $error("cell total or status on a non-report result");

  // an error status never comes with a cell total
  a_err_no_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> cell_total == 16'd0 && byte_out == 8'd0)
    else $error("error report with a cell total");

endmodule

bind csv_line_field_splitter csvs_checker u_csvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .kind       (out_chan.kind),
  .byte_out   (out_chan.byte_out),
  .cell_index (out_chan.cell_index),
  .cell_total (out_chan.cell_total),
  .status     (out_chan.status),
  .run_last   (out_chan.run_last)
);

`default_nettype wire

// ===== bench/tb_csv_line_field_splitter.sv =====
// ---------------------------------------------------------------------------
// tb_csv_line_field_splitter
// Runs a short table of directed lines, then random lines under several
// separator and cell limit settings. Every result beat is checked against a
// local model of the cell, quote and line break rules.
// ---------------------------------------------------------------------------

module tb_csv_line_field_splitter;
  timeunit 1ns;
  timeprecision 1ps;
  import csvs_pkg::*;

  localparam int HOLD_CYCLES     = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int RAND_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int DIR_ROWS        = 26;

  typedef struct packed {
    res_t res;
    logic run_last;
  } beat_t;

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    logic [15:0] total;
    status_t     st;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  csvs_in_if  in_if ();
  csvs_out_if out_if ();

  csv_line_field_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // directed lines; typed rows carry the line end report read off by hand
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00,      1'b0, 1'b0, 16'd0, ST_OK},
    '{8'hFF,      1'b1, 1'b1, 16'd1, ST_OK},
    '{CR_BYTE,    1'b1, 1'b1, 16'd0, ST_OK},
    '{QUOTE_BYTE, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h61,      1'b0, 1'b0, 16'd0, ST_OK},
    '{QUOTE_BYTE, 1'b0, 1'b0, 16'd0, ST_OK},
    '{QUOTE_BYTE, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h2C,      1'b0, 1'b0, 16'd0, ST_OK},
    '{QUOTE_BYTE, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h2C,      1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h62,      1'b1, 1'b1, 16'd2, ST_OK},
    '{QUOTE_BYTE, 1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h78,      1'b1, 1'b1, 16'd0, ST_OPEN_QUOTE},
    '{QUOTE_BYTE, 1'b0, 1'b0, 16'd0, ST_OK},
    '{QUOTE_BYTE, 1'b0, 1'b0, 16'd0, ST_OK},
    '{LF_BYTE,    1'b1, 1'b1, 16'd1, ST_OK},
    '{CR_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{LF_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{CR_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{LF_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{LF_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{CR_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{CR_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{LF_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{CR_BYTE,    1'b0, 1'b0, 16'd0, ST_OK},
    '{8'h7A,      1'b1, 1'b1, 16'd0, ST_BREAK_OVF}
  };

  logic [7:0]  phase_sep [RAND_PHASES] = '{8'h2C, 8'h3B, QUOTE_BYTE, CR_BYTE,
                                          LF_BYTE, 8'h00, 8'hFF};
  logic [15:0] phase_max [RAND_PHASES] = '{16'hFFFF, 16'd1, 16'd3, 16'd2,
                                          16'd4, 16'd6, 16'hFFFF};

  // side info that travels with the beat on the input channel
  logic        row_typed = 1'b0;
  logic [15:0] row_total = 16'd0;
  status_t     row_st    = ST_OK;

  logic calm     = 1'b0;
  logic hold_req = 1'b0;
  int   fail_cnt = 0;

  // splitter state as seen by the checker
  logic [7:0]  sep_byte    = SEPARATOR_RST;
  logic [15:0] cell_limit  = MAX_CELLS_RST;
  logic        in_quotes   = 1'b0;
  logic        quote_pend  = 1'b0;
  logic        got_content = 1'b0;
  logic [15:0] cell_no     = 16'd0;
  int          held_cnt    = 0;
  logic        held_lf [BREAK_HOLD_DEPTH_DEF];
  status_t     line_err    = ST_OK;

  beat_t step_beats[$];
  beat_t expected_beats[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void add_beat(kind_t k, logic [7:0] b, logic [15:0] idx,
                                   logic [15:0] tot, status_t st);
    beat_t bt;
    bt.res.kind       = k;
    bt.res.byte_out   = b;
    bt.res.cell_index = idx;
    bt.res.cell_total = tot;
    bt.res.status     = st;
    bt.run_last       = 1'b0;
    step_beats.insert(step_beats.size(), bt);
  endfunction

  function automatic void note_error(status_t code);
    if (line_err == ST_OK) line_err = code;
  endfunction

  function automatic void split_plain(logic [7:0] c);
    if (c == sep_byte && !in_quotes) begin
      if ({1'b0, cell_no} + 17'd1 >= {1'b0, cell_limit}) begin
        note_error(ST_TOO_MANY);
      end else begin
        add_beat(KIND_CELL_END, 8'h00, cell_no, 16'd0, ST_OK);
        cell_no = cell_no + 16'd1;
      end
    end else begin
      add_beat(KIND_BYTE, c, cell_no, 16'd0, ST_OK);
    end
  endfunction

  function automatic void close_pending();
    if (quote_pend) begin
      quote_pend = 1'b0;
      in_quotes  = 1'b0;
    end
  endfunction

  function automatic void split_step(logic [7:0] c, logic last);
    status_t     st;
    logic [15:0] total;
    if (c == CR_BYTE || c == LF_BYTE) begin
      close_pending();
      if (held_cnt < BREAK_HOLD_DEPTH_DEF) begin
        held_lf[held_cnt] = (c == LF_BYTE);
        held_cnt++;
      end else begin
        note_error(ST_BREAK_OVF);
      end
    end else begin
      got_content = 1'b1;
      if (c != QUOTE_BYTE) close_pending();
      // held breaks come out as ordinary bytes ahead of this one
      for (int i = 0; i < held_cnt; i++) split_plain(held_lf[i] ? LF_BYTE : CR_BYTE);
      held_cnt = 0;
      if (c == QUOTE_BYTE) begin
        if (quote_pend) begin
          quote_pend = 1'b0;
          add_beat(KIND_BYTE, QUOTE_BYTE, cell_no, 16'd0, ST_OK);
        end else if (!in_quotes) begin
          in_quotes = 1'b1;
        end else begin
          quote_pend = 1'b1;
        end
      end else begin
        split_plain(c);
      end
    end
    if (last) begin
      st    = line_err;
      total = 16'd0;
      if (got_content) begin
        if (st == ST_OK && in_quotes && !quote_pend) st = ST_OPEN_QUOTE;
        if (st == ST_OK) total = cell_no + 16'd1;
      end
      add_beat(KIND_LINE_END, 8'h00, 16'd0, total, st);
      in_quotes   = 1'b0;
      quote_pend  = 1'b0;
      cell_no     = 16'd0;
      held_cnt    = 0;
      got_content = 1'b0;
      line_err    = ST_OK;
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      fail_cnt++;
    end
  endfunction

  // config writes, input beats and result beats in one place, in that order
  always @(posedge clk) begin
    beat_t want;
    beat_t tail;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_SEPARATOR: sep_byte   = cfg_wdata[7:0];
        CFG_MAX_CELLS: cell_limit = cfg_wdata;
        default: ;
      endcase
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      step_beats.delete();
      split_step(in_if.ch, in_if.line_last);
      if (step_beats.size() > 0) begin
        tail = step_beats.pop_back();
        tail.run_last = 1'b1;
        if (row_typed) begin
          tail.res.cell_total = row_total;
          tail.res.status     = row_st;
        end
        step_beats.insert(step_beats.size(), tail);
      end
      foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual kind %0d byte %0h",
                 $time, out_if.kind, out_if.byte_out);
        fail_cnt++;
      end else begin
        want = expected_beats.pop_front();
        check_field("kind", 16'(want.res.kind), 16'(out_if.kind));
        check_field("byte_out", 16'(want.res.byte_out), 16'(out_if.byte_out));
        check_field("cell_index", want.res.cell_index, out_if.cell_index);
        check_field("cell_total", want.res.cell_total, out_if.cell_total);
        check_field("status", 16'(want.res.status), 16'(out_if.status));
        check_field("run_last", 16'(want.run_last), 16'(out_if.run_last));
      end
    end
  end

  always @(posedge clk) begin
    int idle_cnt;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
      idle_cnt = 0;
    else
      idle_cnt++;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("** csv_line_field_splitter: FAILED **");
      $finish;
    end
  end

  // result side: short random stalls, some long ones, one forced hold-off
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        out_if.ready = 1'b0;
        stall--;
      end else if (calm || $urandom_range(0, 99) < 70) begin
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] line_byte(logic [7:0] sep);
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return sep;
    if (r < 40) return QUOTE_BYTE;
    if (r < 46) return CR_BYTE;
    if (r < 52) return LF_BYTE;
    if (r < 70) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(0, 255));
  endfunction

  // entered and left at a falling edge
  task automatic send_beat(logic [7:0] c, logic last, logic typed, logic [15:0] tot,
                           status_t st);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.ch        = c;
    in_if.line_last = last;
    row_typed       = typed;
    row_total       = tot;
    row_st          = st;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // a break-only beat leaves nothing to wait for, so wait on past the last expected result
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    logic [7:0] line_q[$];
    int         n;
    int         len;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SEPARATOR;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.ch        = 8'h00;
    in_if.line_last = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i])
      send_beat(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].total,
                dir_tab[i].st);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      write_reg(CFG_SEPARATOR, {8'h00, phase_sep[p]});
      write_reg(CFG_MAX_CELLS, phase_max[p]);
      calm = (p == 2);
      if (p == 3) hold_req = 1'b1;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        line_q.delete();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          // now and then a run of breaks, at times long enough to fill the hold store
          if ($urandom_range(0, 99) < 5)
            repeat ($urandom_range(6, 10))
              line_q.insert(line_q.size(), $urandom_range(0, 1) ? CR_BYTE : LF_BYTE);
          line_q.insert(line_q.size(), line_byte(phase_sep[p]));
        end
        if ($urandom_range(0, 2) == 0) begin
          line_q.insert(line_q.size(), CR_BYTE);
          line_q.insert(line_q.size(), LF_BYTE);
        end
        foreach (line_q[k])
          send_beat(line_q[k], k == line_q.size() - 1, 1'b0, 16'd0, ST_OK);
        n += line_q.size();
      end
    end

    calm = 1'b0;
    in_if.valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_cnt == 0)
      $display("** csv_line_field_splitter: PASSED **");
    else
      $display("** csv_line_field_splitter: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/csvs_pkg.sv
sv/csvs_in_if.sv
sv/csvs_out_if.sv
sv/csvs_ctrl.sv
sv/csvs_dp.sv
sv/csv_line_field_splitter.sv
sv/csvs_checker.sv
bench/tb_csv_line_field_splitter.sv
